>>> hw/rtl/hit_time_window_grouper_assert.svh
// Assertion macros used by the checker file of the window grouper.
`ifndef HIT_TIME_WINDOW_GROUPER_ASSERT_SVH
`define HIT_TIME_WINDOW_GROUPER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HTWG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("htwg assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HTWG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("htwg assertion failed");

`endif

>>> hw/rtl/htwg_pkg.sv
// Types, constants and helper functions of the hit time window grouper.
`timescale 1ns / 1ps

package htwg_pkg;

  // Event limits
  localparam int MAX_WINDOWS = 256;
  localparam int SPLIT_PLANE = 7;

  // Field widths
  localparam int TIME_W     = 20;
  localparam int END_W      = TIME_W + 1;
  localparam int PLANE_W    = 6;
  localparam int HITS_W     = 10;
  localparam int NUM_W      = 8;
  localparam int WL_W       = 16;
  localparam int TMO_W      = 19;
  localparam int CLASS_W    = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 19;

  // Window counter holds MAX_WINDOWS itself, the index holds up to MAX_WINDOWS-1
  localparam int WIN_CNT_W = $clog2(MAX_WINDOWS + 1);
  localparam int WIN_IDX_W = $clog2(MAX_WINDOWS);

  // Result queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [CLASS_W-1:0] {
    CLASS_UPSTREAM   = 2'd0,
    CLASS_DOWNSTREAM = 2'd1,
    CLASS_MIXED      = 2'd2
  } window_class_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH      = 1'b0,
    REG_TRIGGER_MAX_OFFSET = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                     has_hit;
    logic signed [TIME_W-1:0] hit_time;
    logic [PLANE_W-1:0]       hit_plane;
    logic                     end_of_event;
  } hit_item_t;

  typedef struct packed {
    logic signed [TIME_W-1:0] window_start;
    window_class_e            window_class;
    logic [HITS_W-1:0]        window_hits;
    logic [NUM_W-1:0]         window_number;
    logic                     window_present;
    logic                     trigger_found;
    logic [NUM_W-1:0]         trigger_window;
    logic                     event_done;
  } win_result_t;

  // Stream class from the lowest and highest plane of a window
  function automatic window_class_e classify(input logic [PLANE_W-1:0] min_p,
                                             input logic [PLANE_W-1:0] max_p);
    window_class_e cls;
    if (max_p < PLANE_W'(SPLIT_PLANE)) begin
      cls = CLASS_UPSTREAM;
    end else if (min_p >= PLANE_W'(SPLIT_PLANE)) begin
      cls = CLASS_DOWNSTREAM;
    end else begin
      cls = CLASS_MIXED;
    end
    return cls;
  endfunction

  // Window report from the open-window state; num_next is one past its index
  function automatic win_result_t make_window(input logic signed [TIME_W-1:0] start,
                                              input logic [PLANE_W-1:0]       min_p,
                                              input logic [PLANE_W-1:0]       max_p,
                                              input logic [HITS_W-1:0]        count,
                                              input logic [WIN_CNT_W-1:0]     num_next);
    win_result_t r;
    logic [WIN_CNT_W-1:0] idx;
    idx              = num_next - WIN_CNT_W'(1);
    r                = '0;
    r.window_start   = start;
    r.window_class   = classify(min_p, max_p);
    r.window_hits    = count;
    r.window_number  = NUM_W'(idx);
    r.window_present = 1'b1;
    return r;
  endfunction

endpackage

>>> hw/rtl/htwg_if.sv
// Channel interfaces of the window grouper: configuration, hits and window results.
`timescale 1ns / 1ps

interface htwg_cfg_if;
  import htwg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface htwg_hit_if;
  import htwg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     has_hit;
  logic signed [TIME_W-1:0] hit_time;
  logic [PLANE_W-1:0]       hit_plane;
  logic                     end_of_event;

  modport source (output valid, has_hit, hit_time, hit_plane, end_of_event, input ready);
  modport sink   (input valid, has_hit, hit_time, hit_plane, end_of_event, output ready);
endinterface

interface htwg_win_if;
  import htwg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TIME_W-1:0] window_start;
  logic [CLASS_W-1:0]       window_class;
  logic [HITS_W-1:0]        window_hits;
  logic [NUM_W-1:0]         window_number;
  logic                     window_present;
  logic                     trigger_found;
  logic [NUM_W-1:0]         trigger_window;
  logic                     event_done;

  modport source (output valid, window_start, window_class, window_hits, window_number,
                  window_present, trigger_found, trigger_window, event_done,
                  input ready);
  modport sink   (input valid, window_start, window_class, window_hits, window_number,
                  window_present, trigger_found, trigger_window, event_done,
                  output ready);
endinterface

>>> hw/rtl/hit_time_window_grouper.sv
// Top level of the hit time window grouper: window state, trigger pick and result queue.
//
//  channel | dir | payload                                          | transfer when
//  cfg_i   | in  | index, data                                      | valid & ready
//  hit_i   | in  | has_hit, hit_time, hit_plane, end_of_event       | valid & ready
//  win_o   | out | window fields, trigger fields, event_done        | valid & ready
//
// One hit item per cycle while the result queue has room; an item is held in the input register,
// then its window update and up to two results are written in the same cycle.
// The four-entry result queue takes an item only with two free entries, so hit_i
// stalls only while win_o holds results back. cfg_i is always ready.
// Reset clears all window state and both registers; there is no clearing pass.
`timescale 1ns / 1ps

module hit_time_window_grouper (
  input  logic        clk_i,
  input  logic        rst_ni,
  htwg_cfg_if.sink    cfg_i,
  htwg_hit_if.sink    hit_i,
  htwg_win_if.source  win_o
);
  import htwg_pkg::*;

  // Configuration registers
  logic [WL_W-1:0]  wl_q;
  logic [TMO_W-1:0] tmo_q;

  // Input register
  logic      s1_valid_q;
  hit_item_t s1_q;

  // Window state of the current event
  logic                     open_q,       open_d,      open_m;
  logic signed [TIME_W-1:0] start_q,      start_d,     start_m;
  logic signed [END_W-1:0]  end_q,        end_d,       end_m;
  logic [PLANE_W-1:0]       minp_q,       minp_d,      minp_m;
  logic [PLANE_W-1:0]       maxp_q,       maxp_d,      maxp_m;
  logic [HITS_W-1:0]        count_q,      count_d,     count_m;
  logic [WIN_CNT_W-1:0]     num_q,        num_d,       num_m;
  logic [TIME_W-1:0]        best_mag_q,   best_mag_d,  best_mag_m;
  logic [WIN_IDX_W-1:0]     best_num_q,   best_num_d,  best_num_m;
  logic                     best_valid_q, best_valid_d, best_valid_m;

  // Result queue
  win_result_t           outq_q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUTQ_CNT_W-1:0] cnt_q;

  // Per-item decode
  logic signed [END_W-1:0] t_ext;
  logic [TIME_W-1:0]       mag;
  logic                    joins, opens, closes;
  logic                    advance, pop;
  win_result_t             res_closed, res_done;
  logic [OUTQ_CNT_W-1:0]   push_n;
  win_result_t             head;

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q  <= '0;
      tmo_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_WINDOW_LENGTH:      wl_q  <= cfg_i.data[WL_W-1:0];
        REG_TRIGGER_MAX_OFFSET: tmo_q <= cfg_i.data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: moves on when the queue has room for two results
  assign advance     = s1_valid_q && (cnt_q <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
  assign hit_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (hit_i.ready) begin
      s1_valid_q <= hit_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_i.ready && hit_i.valid) begin
      s1_q.has_hit      <= hit_i.has_hit;
      s1_q.hit_time     <= hit_i.hit_time;
      s1_q.hit_plane    <= hit_i.hit_plane;
      s1_q.end_of_event <= hit_i.end_of_event;
    end
  end

  // Window update, trigger tracking and result build
  always_comb begin
    t_ext  = END_W'(s1_q.hit_time);
    mag    = s1_q.hit_time[TIME_W-1] ? TIME_W'(-s1_q.hit_time) : TIME_W'(s1_q.hit_time);
    joins  = s1_q.has_hit && open_q && (t_ext < end_q);
    opens  = s1_q.has_hit && !joins && (num_q < WIN_CNT_W'(MAX_WINDOWS));
    closes = opens && open_q;

    // state after the hit
    open_m       = open_q;
    start_m      = start_q;
    end_m        = end_q;
    minp_m       = minp_q;
    maxp_m       = maxp_q;
    count_m      = count_q;
    num_m        = num_q;
    best_mag_m   = best_mag_q;
    best_num_m   = best_num_q;
    best_valid_m = best_valid_q;

    if (joins) begin
      if (count_q != '1) begin
        count_m = count_q + HITS_W'(1);
      end
      if (s1_q.hit_plane < minp_q) begin
        minp_m = s1_q.hit_plane;
      end
      if (s1_q.hit_plane > maxp_q) begin
        maxp_m = s1_q.hit_plane;
      end
    end else if (opens) begin
      open_m  = 1'b1;
      start_m = s1_q.hit_time;
      end_m   = t_ext + $signed({{(END_W - WL_W){1'b0}}, wl_q});
      count_m = HITS_W'(1);
      minp_m  = s1_q.hit_plane;
      maxp_m  = s1_q.hit_plane;
      num_m   = num_q + WIN_CNT_W'(1);
      if (!best_valid_q || (mag < best_mag_q)) begin
        best_valid_m = 1'b1;
        best_mag_m   = mag;
        best_num_m   = WIN_IDX_W'(num_q);
      end
    end

    // report of the window closed by a new one
    res_closed = make_window(start_q, minp_q, maxp_q, count_q, num_q);

    // closing result of the event
    res_done = '0;
    if (open_m) begin
      res_done = make_window(start_m, minp_m, maxp_m, count_m, num_m);
    end
    if (best_valid_m && (best_mag_m <= TIME_W'(tmo_q))) begin
      res_done.trigger_found  = 1'b1;
      res_done.trigger_window = NUM_W'(best_num_m);
    end
    res_done.event_done = 1'b1;

    // next state, back to reset values after the closing item
    open_d       = open_m;
    start_d      = start_m;
    end_d        = end_m;
    minp_d       = minp_m;
    maxp_d       = maxp_m;
    count_d      = count_m;
    num_d        = num_m;
    best_mag_d   = best_mag_m;
    best_num_d   = best_num_m;
    best_valid_d = best_valid_m;
    if (s1_q.end_of_event) begin
      open_d       = 1'b0;
      start_d      = '0;
      end_d        = '0;
      minp_d       = '1;
      maxp_d       = '0;
      count_d      = '0;
      num_d        = '0;
      best_mag_d   = '0;
      best_num_d   = '0;
      best_valid_d = 1'b0;
    end

    push_n = OUTQ_CNT_W'(closes) + OUTQ_CNT_W'(s1_q.end_of_event);
    if (!advance) begin
      push_n = '0;
    end
  end

  // Window state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q       <= 1'b0;
      start_q      <= '0;
      end_q        <= '0;
      minp_q       <= '1;
      maxp_q       <= '0;
      count_q      <= '0;
      num_q        <= '0;
      best_mag_q   <= '0;
      best_num_q   <= '0;
      best_valid_q <= 1'b0;
    end else if (advance) begin
      open_q       <= open_d;
      start_q      <= start_d;
      end_q        <= end_d;
      minp_q       <= minp_d;
      maxp_q       <= maxp_d;
      count_q      <= count_d;
      num_q        <= num_d;
      best_mag_q   <= best_mag_d;
      best_num_q   <= best_num_d;
      best_valid_q <= best_valid_d;
    end
  end

  // Result queue storage: closed window first, closing result after it
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (closes) begin
        outq_q[wr_ptr_q] <= res_closed;
        if (s1_q.end_of_event) begin
          outq_q[wr_ptr_q + OUTQ_PTR_W'(1)] <= res_done;
        end
      end else if (s1_q.end_of_event) begin
        outq_q[wr_ptr_q] <= res_done;
      end
    end
  end

  // Result queue pointers and fill count
  assign pop = win_o.valid && win_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + OUTQ_PTR_W'(push_n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OUTQ_PTR_W'(1);
      end
      cnt_q <= cnt_q + push_n - OUTQ_CNT_W'(pop);
    end
  end

  // Output channel
  assign head                 = outq_q[rd_ptr_q];
  assign win_o.valid          = (cnt_q != '0);
  assign win_o.window_start   = head.window_start;
  assign win_o.window_class   = head.window_class;
  assign win_o.window_hits    = head.window_hits;
  assign win_o.window_number  = head.window_number;
  assign win_o.window_present = head.window_present;
  assign win_o.trigger_found  = head.trigger_found;
  assign win_o.trigger_window = head.trigger_window;
  assign win_o.event_done     = head.event_done;

endmodule

>>> hw/rtl/htwg_checker.sv
// Port-level checks on the window result channel of the grouper, bound to the top level.
`timescale 1ns / 1ps
`include "hit_time_window_grouper_assert.svh"

module htwg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  htwg_win_if.source win
);
  import htwg_pkg::*;

  // a result waiting on the sink keeps its window_start and event_done
  `HTWG_ASSERT_NEXT(a_win_hold, win.valid && !win.ready, win.valid && $stable(win.window_start) && $stable(win.event_done))

  // an event that never opened a window has no trigger
  `HTWG_ASSERT_IMPL(a_empty_no_trig, win.valid && win.event_done && !win.window_present, !win.trigger_found)

  // trigger fields only on the closing result
  `HTWG_ASSERT_IMPL(a_trig_on_done, win.valid && !win.event_done, !win.trigger_found && (win.trigger_window == '0))

  // a reported window holds at least one hit and a real class
  `HTWG_ASSERT_IMPL(a_window_sane, win.valid && win.window_present, (win.window_hits != '0) && (win.window_class != 2'd3))

endmodule

bind hit_time_window_grouper htwg_checker u_htwg_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .win    (win_o)
);

>>> verif/hit_time_window_grouper_tb.sv
// Self-checking testbench of the hit time window grouper: hit stream in, window reports out.
`timescale 1ns / 1ps

module hit_time_window_grouper_tb;
  import htwg_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 85;

  logic clk_i;
  logic rst_ni;

  htwg_cfg_if cfg_bus ();
  htwg_hit_if hit_bus ();
  htwg_win_if win_bus ();

  hit_time_window_grouper i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .hit_i  (hit_bus),
    .win_o  (win_bus)
  );

  // Stimulus and expected window reports
  hit_item_t   pending_hits[$];
  win_result_t window_reports_due[$];

  // Register copies held by the predictor
  logic [WL_W-1:0]  win_len_cfg;
  logic [TMO_W-1:0] trig_max_cfg;

  // Predicted grouping state of the current event
  bit               win_open;
  int               win_start;
  int               win_end;
  logic [PLANE_W-1:0] win_min_plane;
  logic [PLANE_W-1:0] win_max_plane;
  int unsigned      win_count;
  int unsigned      win_next;
  int unsigned      best_mag;
  int unsigned      best_num;
  bit               best_ok;

  // Run bookkeeping
  bit        idle_on;
  int        src_gap;
  int        snk_gap;
  hit_item_t drv_item;
  int        fail_count;
  int        items_accepted;
  int        events_closed;
  int        windows_seen;
  int        triggers_seen;
  int        reg_writes;

  // One line per failure
  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void clear_event();
    win_open      = 1'b0;
    win_start     = 0;
    win_end       = 0;
    win_min_plane = '1;
    win_max_plane = '0;
    win_count     = 0;
    win_next      = 0;
    best_mag      = 0;
    best_num      = 0;
    best_ok       = 1'b0;
  endfunction

  // Report of the window that is open now
  function automatic win_result_t open_window_report();
    win_result_t r;
    r                = '0;
    r.window_start   = win_start[TIME_W-1:0];
    if (win_max_plane < SPLIT_PLANE) begin
      r.window_class = CLASS_UPSTREAM;
    end else if (win_min_plane >= SPLIT_PLANE) begin
      r.window_class = CLASS_DOWNSTREAM;
    end else begin
      r.window_class = CLASS_MIXED;
    end
    r.window_hits    = win_count[HITS_W-1:0];
    r.window_number  = NUM_W'(win_next - 1);
    r.window_present = 1'b1;
    return r;
  endfunction

  // Window grouping and trigger pick for one accepted item
  task automatic group_hit(input hit_item_t it);
    int          t_tick;
    int unsigned mag;
    win_result_t r;
    t_tick = $signed(it.hit_time);
    if (it.has_hit) begin
      if (win_open && t_tick < win_end) begin
        if (win_count < 1023) win_count++;
        if (it.hit_plane < win_min_plane) win_min_plane = it.hit_plane;
        if (it.hit_plane > win_max_plane) win_max_plane = it.hit_plane;
      end else if (win_next < MAX_WINDOWS) begin
        if (win_open) window_reports_due = {window_reports_due, open_window_report()};
        win_open      = 1'b1;
        win_start     = t_tick;
        win_end       = t_tick + int'(win_len_cfg);
        win_count     = 1;
        win_min_plane = it.hit_plane;
        win_max_plane = it.hit_plane;
        mag = (t_tick < 0) ? -t_tick : t_tick;
        // earliest window wins a tie
        if (!best_ok || mag < best_mag) begin
          best_ok  = 1'b1;
          best_mag = mag;
          best_num = win_next;
        end
        win_next++;
      end
    end
    if (it.end_of_event) begin
      r = win_open ? open_window_report() : '0;
      if (best_ok && best_mag <= trig_max_cfg) begin
        r.trigger_found  = 1'b1;
        r.trigger_window = NUM_W'(best_num);
      end
      r.event_done = 1'b1;
      window_reports_due = {window_reports_due, r};
      clear_event();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  task automatic check_window(input win_result_t want);
    check_field("window_start", {win_bus.window_start}, {want.window_start});
    check_field("window_class", win_bus.window_class, want.window_class);
    check_field("window_hits", win_bus.window_hits, want.window_hits);
    check_field("window_number", win_bus.window_number, want.window_number);
    check_field("window_present", win_bus.window_present, want.window_present);
    check_field("trigger_found", win_bus.trigger_found, want.trigger_found);
    check_field("trigger_window", win_bus.trigger_window, want.trigger_window);
    check_field("event_done", win_bus.event_done, want.event_done);
  endtask

  task automatic queue_hit(input bit hh, input int t_tick, input int plane, input bit eoe);
    hit_item_t it;
    it.has_hit      = hh;
    it.hit_time     = TIME_W'(t_tick);
    it.hit_plane    = PLANE_W'(plane);
    it.end_of_event = eoe;
    pending_hits = {pending_hits, it};
  endtask

  // Register write over the config channel; only called while the block is idle
  task automatic write_reg(input cfg_reg_e idx, input int unsigned val);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= CFG_DATA_W'(val);
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == REG_WINDOW_LENGTH) begin
      win_len_cfg = WL_W'(val);
    end else begin
      trig_max_cfg = TMO_W'(val);
    end
    reg_writes++;
  endtask

  // Wait until every item has gone in and every report has come out
  task automatic wait_until_drained();
    while (pending_hits.size() != 0 || hit_bus.valid || window_reports_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly ordered events with random content, some noise and some broken events
  task automatic add_random_events(input int n_items);
    int added;
    int n_hits;
    int mode;
    int t_tick;
    int k;
    int step_max;
    int plane;
    bit broken;
    added    = 0;
    step_max = int'(win_len_cfg) * 2 + 2;
    while (added < n_items) begin
      n_hits = $urandom_range(10);
      mode   = $urandom_range(2);
      broken = ($urandom_range(9) == 0);
      case ($urandom_range(3))
        0: t_tick = $signed(TIME_W'($urandom));
        1: t_tick = $urandom_range(1) ? 524287 - int'($urandom_range(300))
                                      : -524288 + int'($urandom_range(300));
        default: t_tick = int'($urandom_range(4000)) - 2000;
      endcase
      for (k = 0; k <= n_hits; k++) begin
        // stray empty items between hits
        if ($urandom_range(7) == 0) begin
          queue_hit(1'b0, $signed(TIME_W'($urandom)), $urandom_range(63), 1'b0);
          added++;
        end
        if (broken) begin
          t_tick = $signed(TIME_W'($urandom));
        end else if (k > 0) begin
          t_tick = t_tick + int'($urandom_range(step_max));
          if (t_tick > 524287) t_tick = 524287;
        end
        case (mode)
          0:       plane = $urandom_range(SPLIT_PLANE - 1);
          1:       plane = $urandom_range(63, SPLIT_PLANE);
          default: plane = $urandom_range(63);
        endcase
        if (k < n_hits) begin
          queue_hit(1'b1, t_tick, plane, 1'b0);
        end else begin
          queue_hit(1'($urandom_range(1)), t_tick, plane, 1'b1);
        end
        added++;
      end
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hit driver: one item per transfer from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin : drive_hits
    hit_item_t nxt;
    bit        nv;
    if (!rst_ni) begin
      hit_bus.valid        <= 1'b0;
      hit_bus.has_hit      <= 1'b0;
      hit_bus.hit_time     <= '0;
      hit_bus.hit_plane    <= '0;
      hit_bus.end_of_event <= 1'b0;
      src_gap = 0;
    end else begin
      if (hit_bus.valid && hit_bus.ready) begin
        group_hit(drv_item);
        items_accepted++;
      end
      if (!hit_bus.valid || hit_bus.ready) begin
        nv = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_hits.size() != 0) begin
          nxt      = pending_hits.pop_front();
          drv_item = nxt;
          nv       = 1'b1;
          hit_bus.has_hit      <= nxt.has_hit;
          hit_bus.hit_time     <= nxt.hit_time;
          hit_bus.hit_plane    <= nxt.hit_plane;
          hit_bus.end_of_event <= nxt.end_of_event;
          if (idle_on && $urandom_range(5) == 0) src_gap = $urandom_range(5, 1);
        end
        hit_bus.valid <= nv;
      end
    end
  end

  // Report monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin : watch_reports
    win_result_t want;
    if (!rst_ni) begin
      win_bus.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (win_bus.valid && win_bus.ready) begin
        if (win_bus.window_present) windows_seen++;
        if (win_bus.event_done) events_closed++;
        if (win_bus.trigger_found) triggers_seen++;
        if (window_reports_due.size() == 0) begin
          report_error("window report with nothing outstanding");
        end else begin
          want = window_reports_due.pop_front();
          check_window(want);
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        win_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(5) == 0) begin
        snk_gap = $urandom_range(4);
        win_bus.ready <= 1'b0;
      end else begin
        win_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int cyc;
    for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d reports outstanding",
             CYCLE_LIMIT, window_reports_due.size());
    $display("** hit_time_window_grouper: FAILED **");
    $finish;
  end

  // Sequence of settings and stimulus
  initial begin : run_seq
    int ph;
    int k;
    int base;
    int unsigned wl;
    int unsigned tmo;
    rst_ni               = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = REG_WINDOW_LENGTH;
    cfg_bus.data         = '0;
    hit_bus.valid        = 1'b0;
    hit_bus.has_hit      = 1'b0;
    hit_bus.hit_time     = '0;
    hit_bus.hit_plane    = '0;
    hit_bus.end_of_event = 1'b0;
    win_bus.ready        = 1'b0;
    win_len_cfg          = '0;
    trig_max_cfg         = '0;
    idle_on              = 1'b1;
    clear_event();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: short windows, moderate trigger limit
    write_reg(REG_WINDOW_LENGTH, 10);
    write_reg(REG_TRIGGER_MAX_OFFSET, 100);
    queue_hit(1'b0, 0, 0, 1'b1);              // event with no hit at all
    queue_hit(1'b0, 12345, 33, 1'b0);         // ignored empty item
    queue_hit(1'b0, 0, 0, 1'b1);
    queue_hit(1'b1, -5, 0, 1'b0);             // upstream, then downstream, then mixed
    queue_hit(1'b1, -3, 6, 1'b0);
    queue_hit(1'b1, 5, 7, 1'b0);
    queue_hit(1'b1, 6, 63, 1'b0);
    queue_hit(1'b1, 20, 3, 1'b0);
    queue_hit(1'b1, 25, 40, 1'b1);
    queue_hit(1'b1, 100, 10, 1'b0);           // earlier hit joins the open window
    queue_hit(1'b1, 95, 2, 1'b0);
    queue_hit(1'b1, 101, 8, 1'b1);
    queue_hit(1'b1, -524288, 63, 1'b1);
    queue_hit(1'b1, 524287, 0, 1'b1);
    queue_hit(1'b1, -50, 30, 1'b0);           // equal magnitudes, first one kept
    queue_hit(1'b1, 50, 31, 1'b1);
    wait_until_drained();

    // Directed: zero length windows, widest trigger limit
    write_reg(REG_WINDOW_LENGTH, 0);
    write_reg(REG_TRIGGER_MAX_OFFSET, 524287);
    queue_hit(1'b1, 1, 5, 1'b0);
    queue_hit(1'b1, 1, 9, 1'b0);
    queue_hit(1'b1, 1, 9, 1'b0);
    queue_hit(1'b0, 0, 0, 1'b1);
    queue_hit(1'b1, -524288, 7, 1'b1);        // most negative start is never the trigger
    queue_hit(1'b1, -524287, 7, 1'b1);
    wait_until_drained();

    // Random phases over several settings
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       begin wl = 0;     tmo = 0;      end
        1:       begin wl = 65535; tmo = 524287; end
        2:       begin wl = 3;     tmo = 1000;   end
        3:       begin wl = 65535; tmo = 0;      end
        5:       begin wl = 1;     tmo = 524287; end
        7:       begin wl = 20;    tmo = 5000;   end
        default: begin wl = $urandom_range(200, 1); tmo = $urandom_range(524287); end
      endcase
      idle_on = (ph % 3 != 2) && (ph != RAND_PHASES - 1);
      write_reg(REG_WINDOW_LENGTH, wl);
      write_reg(REG_TRIGGER_MAX_OFFSET, tmo);
      add_random_events(PHASE_ITEMS);
      if (ph == 2) begin
        // more windows than the event can hold; late hits still join the last one
        for (k = 0; k < 270; k++) queue_hit(1'b1, k * 5 - 600, k % 64, 1'b0);
        queue_hit(1'b1, 676, 9, 1'b0);
        queue_hit(1'b1, 677, 63, 1'b1);
      end
      if (ph == 3) begin
        // one window with more hits than the count can hold
        base = int'($urandom_range(100)) - 50;
        for (k = 0; k < 1030; k++) queue_hit(1'b1, base + k / 100, $urandom_range(63), 1'b0);
        queue_hit(1'b0, 0, 0, 1'b1);
      end
      wait_until_drained();
    end

    if (window_reports_due.size() != 0) begin
      report_error($sformatf("%0d window reports never arrived", window_reports_due.size()));
    end
    $display("Run covered %0d hit items over %0d events, %0d windows, %0d triggers,",
             items_accepted, events_closed, windows_seen, triggers_seen);
    $display("with %0d register writes across %0d settings; %0d mismatches",
             reg_writes, RAND_PHASES + 2, fail_count);
    if (fail_count == 0) begin
      $display("** hit_time_window_grouper: PASSED **");
    end else begin
      $display("** hit_time_window_grouper: FAILED **");
    end
    $finish;
  end

endmodule
